// File: rtl/hsm_pkg.sv
// Shared constants and pipeline payload type for the HDR pixel encoder.
`default_nettype none
package hsm_pkg;

   localparam int FRACTION_BITS = 16;
   localparam logic [31:0] SCALE_RESET = 32'(64'd1 << FRACTION_BITS);
   // 4 * 255^2 and 255^2
   localparam logic [17:0] K_QUAD = 18'd260100;
   localparam logic [15:0] K_SQR  = 16'd65025;

   typedef struct packed {
      logic              zero;
      logic [31:0]       scale;
      logic [49:0]       alpha_rhs;
      logic [47:0]       div;
      logic [2:0][65:0]  chan_rhs;
      logic [7:0]        alpha_code;
      logic [2:0][7:0]   chan_code;
      logic [17:0]       alpha_sq;
      logic [2:0][17:0]  chan_sq;
   } pix_type;

endpackage
`default_nettype wire

// File: rtl/hdr_shared_multiplier_pixel_encode_unit.sv
// Top level of the pipelined HDR shared-multiplier pixel encoder.
//
// Input channel req_*: one pixel per transaction (signed Q16.16 red, green,
// blue and an 8-bit multiplier code). Output channel rsp_*: one result per
// pixel, the first-pass multiplier code and three channel codes, in order.
// csr_wr_en/csr_wr_data write hdr_scale; write only while the pipe is empty.
// Four setup stages (max/clamp, products, remainder,
// scaled remainder) then eight bit steps of the code search, each a squaring
// stage and a multiply-compare stage. Throughput is one pixel per cycle unless rsp stalls.
// Reset empties the pipe and sets hdr_scale to 1.0.
// The whole pipe advances together: when rsp_valid is high and rsp_ready low
// everything holds and req_ready drops; bubbles move on while rsp is empty.
`default_nettype none
module hdr_shared_multiplier_pixel_encode_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [31:0]        csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_red_in,
   input  wire logic signed [31:0] req_green_in,
   input  wire logic signed [31:0] req_blue_in,
   input  wire logic [7:0]         req_alpha_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_alpha_code,
   output logic [7:0]              rsp_red_code,
   output logic [7:0]              rsp_green_code,
   output logic [7:0]              rsp_blue_code
);

   logic        en;
   logic [31:0] hdr_scale_ff;
   logic [3:0]  fv_ff;

   // setup stage 1
   logic [2:0][30:0] comp1_ff;
   logic [16:0]      asq1_ff;
   logic [30:0]      m1_ff;
   logic [31:0]      s1_ff;
   logic [2:0][30:0] comp_in;
   logic [30:0]      mx;
   logic [31:0]      m_cl;
   // setup stage 2
   logic [2:0][46:0] n2_ff;
   logic [47:0]      d2_ff;
   logic [49:0]      arhs2_ff;
   logic [31:0]      s2_ff;
   // setup stage 3
   logic [2:0][47:0] rest3_ff;
   logic [47:0]      d3_ff;
   logic [49:0]      arhs3_ff;
   logic [31:0]      s3_ff;
   // setup stage 4
   hsm_pkg::pix_type p4_ff, p4_in;

   hsm_pkg::pix_type step_data [9];
   logic [8:0]       step_valid;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_comb begin
      comp_in[0] = req_red_in[31]   ? 31'd0 : req_red_in[30:0];
      comp_in[1] = req_green_in[31] ? 31'd0 : req_green_in[30:0];
      comp_in[2] = req_blue_in[31]  ? 31'd0 : req_blue_in[30:0];
      mx = comp_in[0];
      if (comp_in[1] > mx) mx = comp_in[1];
      if (comp_in[2] > mx) mx = comp_in[2];
      m_cl = ({1'b0, mx} > hdr_scale_ff) ? hdr_scale_ff : {1'b0, mx};
   end

   always_comb begin
      p4_in            = '0;
      p4_in.zero       = (s3_ff == 32'd0);
      p4_in.scale      = s3_ff;
      p4_in.alpha_rhs  = arhs3_ff;
      p4_in.div        = d3_ff;
      for (int i = 0; i < 3; i++) begin
         p4_in.chan_rhs[i] = {18'd0, rest3_ff[i]} * {48'd0, hsm_pkg::K_QUAD};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_scale_ff <= hsm_pkg::SCALE_RESET;
         fv_ff        <= '0;
      end else begin
         if (csr_wr_en) hdr_scale_ff <= csr_wr_data;
         if (en) fv_ff <= {fv_ff[2:0], req_valid};
      end
      if (en) begin
         comp1_ff <= comp_in;
         asq1_ff  <= 17'({8'd0, 9'(req_alpha_in) + 9'd1} * {8'd0, 9'(req_alpha_in) + 9'd1});
         m1_ff    <= m_cl[30:0];
         s1_ff    <= hdr_scale_ff;

         for (int i = 0; i < 3; i++) begin
            n2_ff[i] <= {16'd0, comp1_ff[i]} * {31'd0, hsm_pkg::K_SQR};
         end
         d2_ff    <= {31'd0, asq1_ff} * {16'd0, s1_ff};
         arhs2_ff <= {19'd0, m1_ff} * {32'd0, hsm_pkg::K_QUAD};
         s2_ff    <= s1_ff;

         for (int i = 0; i < 3; i++) begin
            rest3_ff[i] <= ({1'b0, n2_ff[i]} > d2_ff) ? 48'd0 : d2_ff - {1'b0, n2_ff[i]};
         end
         d3_ff    <= d2_ff;
         arhs3_ff <= arhs2_ff;
         s3_ff    <= s2_ff;

         p4_ff    <= p4_in;
      end
   end

   assign step_data[0]  = p4_ff;
   assign step_valid[0] = fv_ff[3];

   for (genvar g = 0; g < 8; g++) begin : g_step
      hsm_code_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step_mask (8'd128 >> g),
         .in_valid  (step_valid[g]),
         .in_data   (step_data[g]),
         .out_valid (step_valid[g+1]),
         .out_data  (step_data[g+1])
      );
   end

   assign rsp_valid      = step_valid[8];
   assign rsp_alpha_code = step_data[8].alpha_code;
   assign rsp_red_code   = step_data[8].zero ? 8'd0 : step_data[8].chan_code[0];
   assign rsp_green_code = step_data[8].zero ? 8'd0 : step_data[8].chan_code[1];
   assign rsp_blue_code  = step_data[8].zero ? 8'd0 : step_data[8].chan_code[2];

endmodule
`default_nettype wire

// File: rtl/hsm_code_step.sv
// One bit of the code search: square the trial odd number, then compare.
`default_nettype none
module hsm_code_step (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic [7:0]      step_mask,
   input  wire logic            in_valid,
   input  wire hsm_pkg::pix_type in_data,
   output logic                 out_valid,
   output hsm_pkg::pix_type     out_data
);

   hsm_pkg::pix_type sq_ff, sq_in, cmp_ff, cmp_in;
   logic             sq_valid_ff, cmp_valid_ff;

   function automatic logic [17:0] odd_sq(input logic [7:0] trial);
      logic [8:0] h;
      h = {trial, 1'b0} - 9'd1;
      return 18'({9'd0, h} * {9'd0, h});
   endfunction

   always_comb begin
      sq_in = in_data;
      sq_in.alpha_sq = odd_sq(in_data.alpha_code | step_mask);
      for (int i = 0; i < 3; i++) begin
         sq_in.chan_sq[i] = odd_sq(in_data.chan_code[i] | step_mask);
      end
   end

   always_comb begin
      cmp_in = sq_ff;
      if (({32'd0, sq_ff.alpha_sq} * {18'd0, sq_ff.scale}) <= sq_ff.alpha_rhs) begin
         cmp_in.alpha_code = sq_ff.alpha_code | step_mask;
      end
      for (int i = 0; i < 3; i++) begin
         if (({48'd0, sq_ff.chan_sq[i]} * {18'd0, sq_ff.div}) <= sq_ff.chan_rhs[i]) begin
            cmp_in.chan_code[i] = sq_ff.chan_code[i] | step_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff  <= in_valid;
         cmp_valid_ff <= sq_valid_ff;
      end
      if (en) begin
         sq_ff  <= sq_in;
         cmp_ff <= cmp_in;
      end
   end

   assign out_valid = cmp_valid_ff;
   assign out_data  = cmp_ff;

endmodule
`default_nettype wire

// File: rtl/hsm_checker.sv
// Port-level checks for the HDR pixel encoder and their bind.
`default_nettype none
module hsm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_alpha_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_alpha_code))
      else $error("rsp payload changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind hdr_shared_multiplier_pixel_encode_unit hsm_checker u_hsm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_alpha_code (rsp_alpha_code)
);
`default_nettype wire
